// File: hw/rtl/stdm_pkg.sv
// Shared types and constants for the sorted triplet duplicate merge block.
`timescale 1ns / 1ps
package stdm_pkg;

   // Field widths
   localparam int KEY_BITS   = 32;
   localparam int KEY_W      = 32;
   localparam int VAL_W      = 64;
   localparam int IDX_W      = 16;
   localparam int DOF_W      = 16;
   localparam int REQ_DATA_W = KEY_W + VAL_W;
   localparam int RSP_DATA_W = IDX_W + IDX_W + VAL_W;

   // Only the low KEY_BITS bits of a key take part
   localparam logic [KEY_W-1:0] KEY_MASK =
      (KEY_BITS >= KEY_W) ? {KEY_W{1'b1}} : KEY_W'((64'd1 << KEY_BITS) - 64'd1);

   localparam logic [DOF_W-1:0] DOF_RESET = DOF_W'(3);

   // Divider: one quotient bit per step
   localparam int DIV_STEPS = KEY_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Saturation limits
   localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MERGE,
      ST_FLUSH,
      ST_DIVIDE,
      ST_SEND
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic merge;
      logic flush;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic close_run;
      logic sum_nonzero;
      logic final_in;
      logic div_done;
      logic res_end;
   } stat_type;

endpackage

// File: hw/rtl/stdm_div.sv
// Iterative restoring divider: key by dof_count, one quotient bit a cycle.
`timescale 1ns / 1ps
module stdm_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [stdm_pkg::KEY_W-1:0] dividend,
   input  logic [stdm_pkg::DOF_W-1:0] divisor,
   output logic                       done,
   output logic [stdm_pkg::KEY_W-1:0] quotient,
   output logic [stdm_pkg::DOF_W-1:0] remainder
);
   import stdm_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [KEY_W-1:0]     q_ff, q_in;
   logic [DOF_W-1:0]     rem_ff, rem_in;
   logic [DOF_W-1:0]     dvs_ff, dvs_in;
   logic [DOF_W:0]       shift_w;
   logic [DOF_W:0]       diff_w;

   // One shift and trial subtract per step
   always_comb begin
      shift_w = {rem_ff, q_ff[KEY_W-1]};
      diff_w  = shift_w - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         q_in    = dividend;
         rem_in  = '0;
         // a zero divisor acts as one
         dvs_in  = (divisor == '0) ? DOF_W'(1) : divisor;
      end else if (busy_ff) begin
         if (shift_w >= {1'b0, dvs_ff}) begin
            rem_in = diff_w[DOF_W-1:0];
            q_in   = {q_ff[KEY_W-2:0], 1'b1};
         end else begin
            rem_in = shift_w[DOF_W-1:0];
            q_in   = {q_ff[KEY_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = q_ff;
   assign remainder = rem_ff;

endmodule

// File: hw/rtl/stdm_dpath.sv
// Datapath: run state, saturating accumulator, result register and divider.
`timescale 1ns / 1ps
module stdm_dpath (
   input  logic                            clock,
   input  logic                            reset,
   input  stdm_pkg::cmd_type               cmd,
   output stdm_pkg::stat_type              stat,
   input  logic [stdm_pkg::KEY_W-1:0]      in_key,
   input  logic [stdm_pkg::VAL_W-1:0]      in_value,
   input  logic                            in_final,
   input  logic                            csr_write,
   input  logic [stdm_pkg::DOF_W-1:0]      csr_value,
   output logic [stdm_pkg::IDX_W-1:0]      res_row,
   output logic [stdm_pkg::IDX_W-1:0]      res_col,
   output logic [stdm_pkg::VAL_W-1:0]      res_value,
   output logic                            res_valid,
   output logic                            res_end
);
   import stdm_pkg::*;

   // Latched request
   logic [KEY_W-1:0]        key_ff;
   logic signed [VAL_W-1:0] val_ff;
   logic                    fin_ff;

   // Run state
   logic [KEY_W-1:0]        open_key_ff, open_key_in;
   logic signed [VAL_W-1:0] sum_ff, sum_in;
   logic                    run_open_ff, run_open_in;

   // Result register
   logic [IDX_W-1:0]        row_ff, row_in;
   logic [IDX_W-1:0]        col_ff, col_in;
   logic [VAL_W-1:0]        rval_ff, rval_in;
   logic                    rvalid_ff, rvalid_in;
   logic                    rend_ff, rend_in;

   logic [DOF_W-1:0]        dof_ff;

   logic                    same_key;
   logic                    close_run;
   logic                    sum_nz;
   logic signed [VAL_W-1:0] add_w;
   logic signed [VAL_W-1:0] sat_w;
   logic                    div_start;
   logic                    div_done;
   logic [KEY_W-1:0]        div_q;
   logic [DOF_W-1:0]        div_r;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         dof_ff <= DOF_RESET;
      end else if (csr_write) begin
         dof_ff <= csr_value;
      end
   end

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff <= in_key & KEY_MASK;
         val_ff <= in_value;
         fin_ff <= in_final;
      end
   end

   // Saturating add of the request into the open run
   always_comb begin
      add_w = sum_ff + val_ff;
      if ((sum_ff[VAL_W-1] == val_ff[VAL_W-1]) && (add_w[VAL_W-1] != sum_ff[VAL_W-1])) begin
         sat_w = sum_ff[VAL_W-1] ? VAL_MIN : VAL_MAX;
      end else begin
         sat_w = add_w;
      end
   end

   assign same_key  = run_open_ff && (key_ff == open_key_ff);
   assign sum_nz    = (sum_ff != '0);
   assign close_run = run_open_ff && !same_key && sum_nz;

   // Run update, flush and result capture
   always_comb begin
      open_key_in = open_key_ff;
      sum_in      = sum_ff;
      run_open_in = run_open_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      rval_in     = rval_ff;
      rvalid_in   = rvalid_ff;
      rend_in     = rend_ff;
      div_start   = 1'b0;
      if (cmd.merge) begin
         open_key_in = key_ff;
         run_open_in = 1'b1;
         sum_in      = same_key ? sat_w : val_ff;
         if (close_run) begin
            rval_in   = sum_ff;
            rvalid_in = 1'b1;
            rend_in   = 1'b0;
            div_start = 1'b1;
         end
      end else if (cmd.flush) begin
         open_key_in = '0;
         sum_in      = '0;
         run_open_in = 1'b0;
         rend_in     = 1'b1;
         if (sum_nz) begin
            rval_in   = sum_ff;
            rvalid_in = 1'b1;
            div_start = 1'b1;
         end else begin
            // bare end marker
            rval_in   = '0;
            rvalid_in = 1'b0;
            row_in    = '0;
            col_in    = '0;
         end
      end
      if (div_done) begin
         row_in = div_r;
         col_in = div_q[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_key_ff <= '0;
         sum_ff      <= '0;
         run_open_ff <= 1'b0;
      end else begin
         open_key_ff <= open_key_in;
         sum_ff      <= sum_in;
         run_open_ff <= run_open_in;
      end
      row_ff    <= row_in;
      col_ff    <= col_in;
      rval_ff   <= rval_in;
      rvalid_ff <= rvalid_in;
      rend_ff   <= rend_in;
   end

   // Key split into column and row
   stdm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (open_key_ff),
      .divisor   (dof_ff),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   assign stat.close_run   = close_run;
   assign stat.sum_nonzero = sum_nz;
   assign stat.final_in    = fin_ff;
   assign stat.div_done    = div_done;
   assign stat.res_end     = rend_ff;

   assign res_row   = row_ff;
   assign res_col   = col_ff;
   assign res_value = rval_ff;
   assign res_valid = rvalid_ff;
   assign res_end   = rend_ff;

endmodule

// File: hw/rtl/stdm_ctrl.sv
// Controller state machine: sequences merge, flush, division and result hand-off.
`timescale 1ns / 1ps
module stdm_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output stdm_pkg::cmd_type  cmd,
   input  stdm_pkg::stat_type stat
);
   import stdm_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MERGE;
            end
         end
         ST_MERGE: begin
            cmd.merge = 1'b1;
            priority if (stat.close_run) begin
               state_in = ST_DIVIDE;
            end else if (stat.final_in) begin
               state_in = ST_FLUSH;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            cmd.flush = 1'b1;
            state_in  = stat.sum_nonzero ? ST_DIVIDE : ST_SEND;
         end
         ST_DIVIDE: begin
            if (stat.div_done) begin
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               // a closed run ahead of a final request still owes the flush
               state_in = (stat.final_in && !stat.res_end) ? ST_FLUSH : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: hw/rtl/sorted_triplet_duplicate_merge.sv
// Top level: merges runs of equal keys in a sorted triplet stream.
//
//  channel | direction | handshake              | contents
//  req     | in        | req_tvalid/req_tready  | key, value, last = final entry
//  rsp     | out       | rsp_tvalid/rsp_tready  | row, column, sum, user = valid, last = end
//  csr     | in        | csr_valid/csr_ready    | dof_count
//
// One request at a time. A request that closes no nonzero run and is not
// final passes from acceptance through the merge state back to idle. A
// result carrying an entry first passes through the iterative divider (one
// quotient step per key bit, then the done flag); every result, bare end
// marker included, then waits in the send state until taken. The final
// request also passes the flush state. A stalled result holds the block
// until taken. Reset is synchronous, clears the run state, sets dof_count to 3.
`timescale 1ns / 1ps
module sorted_triplet_duplicate_merge (
   input  logic                                clock,
   input  logic                                reset,
   // key [31:0], value [95:32]
   input  logic [stdm_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                req_tlast,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // row [15:0], column [31:16], merged value [95:32]
   output logic [stdm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // entry valid [0]
   output logic                                rsp_tuser,
   output logic                                rsp_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [stdm_pkg::DOF_W-1:0]          csr_data,
   input  logic                                csr_valid,
   output logic                                csr_ready
);
   import stdm_pkg::*;

   cmd_type          cmd;
   stat_type         stat;
   logic [IDX_W-1:0] res_row;
   logic [IDX_W-1:0] res_col;
   logic [VAL_W-1:0] res_value;
   logic             res_valid;
   logic             res_end;

   assign csr_ready = 1'b1;

   stdm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .cmd       (cmd),
      .stat      (stat)
   );

   stdm_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .in_key    (req_tdata[KEY_W-1:0]),
      .in_value  (req_tdata[REQ_DATA_W-1:KEY_W]),
      .in_final  (req_tlast),
      .csr_write (csr_valid & csr_ready),
      .csr_value (csr_data),
      .res_row   (res_row),
      .res_col   (res_col),
      .res_value (res_value),
      .res_valid (res_valid),
      .res_end   (res_end)
   );

   assign rsp_tdata = {res_value, res_col, res_row};
   assign rsp_tuser = res_valid;
   assign rsp_tlast = res_end;

endmodule
